/* design/xor_double_stream_encoder_unit_defines.svh */
// Assertion macros used by the XOR stream encoder back end.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef XOR_DOUBLE_STREAM_ENCODER_UNIT_DEFINES_SVH
`define XOR_DOUBLE_STREAM_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, off during reset.
`define XDSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define XDSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/xdse_pkg.sv */
// Shared types and constants of the XOR stream encoder.
// No dependencies.
package xdse_pkg;

  localparam int unsigned WordBits = 64;
  localparam int unsigned LeadBits = 5;
  localparam int unsigned LenBits  = 6;
  localparam int unsigned QDepth   = 2;

  localparam logic [LeadBits-1:0] LeadMax  = 5'd31;
  localparam logic [6:0]          LenWord  = 7'd64;
  localparam logic [6:0]          LenZero  = 7'd1;
  localparam logic [6:0]          LenCtl   = 7'd2;
  localparam logic [6:0]          LenHdr   = 7'd13;
  localparam logic [1:0]          CtlReuse = 2'b10;
  localparam logic [1:0]          CtlNew   = 2'b11;

  typedef enum logic [1:0] {
    KIND_RAW,
    KIND_ZERO,
    KIND_REUSE,
    KIND_NEW
  } kind_e;

  // One classified item handed from front to back.
  typedef struct packed {
    kind_e                kind;
    logic [WordBits-1:0]  data;   // raw value or XOR
    logic [5:0]           shamt;  // trailing shift of the payload
    logic [LeadBits-1:0]  lead;   // header leading count
    logic [6:0]           len;    // payload length, 1..64
  } xdse_entry_t;

endpackage

/* design/xor_double_stream_encoder_unit.sv */
// XOR stream encoder for 64-bit sample patterns. Each value yields one chunk
// (raw first value, or a single '0' for a repeat) or two chunks (control/header,
// then meaningful bits), MSB first and right-aligned. The front end registers
// the XOR and classifies it in the next cycle; a two-entry queue decouples it
// from the back end, which issues one chunk per cycle from its output register
// while pop is held and the queue is not empty; the front end keeps taking values
// until the queue fills. The first chunk of an item reaches the result ports
// through the front-end register, the queue and the output register.
module xor_double_stream_encoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [63:0] value_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] chunk_bits_o,
  output logic [6:0]  chunk_length_o,
  output logic        last_o
);
  import xdse_pkg::*;

  logic        fq_push, fq_ready, qb_valid, qb_pop;
  xdse_entry_t fq_entry, qb_entry;

  xdse_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .value_i   (value_i),
    .q_push_o  (fq_push),
    .q_entry_o (fq_entry),
    .q_ready_i (fq_ready)
  );

  xdse_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .entry_i (fq_entry),
    .ready_o (fq_ready),
    .valid_o (qb_valid),
    .entry_o (qb_entry),
    .pop_i   (qb_pop)
  );

  xdse_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (qb_valid),
    .q_entry_i      (qb_entry),
    .q_pop_o        (qb_pop),
    .empty          (empty),
    .pop            (pop),
    .chunk_bits_o   (chunk_bits_o),
    .chunk_length_o (chunk_length_o),
    .last_o         (last_o)
  );

endmodule

/* design/xdse_front.sv */
// Front end: takes values, XORs each with the previous one (the first passes raw), counts zeros,
// tests against the stored window and pushes a classified entry. Uses xdse_pkg.
module xdse_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic [63:0]             value_i,
  output logic                    q_push_o,
  output xdse_pkg::xdse_entry_t   q_entry_o,
  input  logic                    q_ready_i
);
  import xdse_pkg::*;

  logic                prev_seen_q, prev_seen_d;
  logic [WordBits-1:0] prev_q, prev_d;
  logic                s1_valid_q, s1_valid_d;
  logic                s1_raw_q, s1_raw_d;
  logic [WordBits-1:0] s1_x_q, s1_x_d;
  logic                win_valid_q, win_valid_d;
  logic [LeadBits-1:0] win_lead_q, win_lead_d;
  logic [5:0]          win_trail_q, win_trail_d;

  logic                accept, advance;
  logic [WordBits-1:0] x_rev;
  logic [5:0]          lz, tz;
  logic [LeadBits-1:0] lz_clamp;
  logic                reuse;
  xdse_entry_t         entry;

  // Six halving steps; x must be nonzero for a meaningful count.
  function automatic logic [5:0] count_tz(input logic [WordBits-1:0] x);
    logic [WordBits-1:0] v;
    logic [5:0]          n;
    v = x;
    n = '0;
    if (v[31:0] == '0) begin n = n + 6'd32; v = v >> 32; end
    if (v[15:0] == '0) begin n = n + 6'd16; v = v >> 16; end
    if (v[7:0]  == '0) begin n = n + 6'd8;  v = v >> 8;  end
    if (v[3:0]  == '0) begin n = n + 6'd4;  v = v >> 4;  end
    if (v[1:0]  == '0) begin n = n + 6'd2;  v = v >> 2;  end
    if (v[0]    == 1'b0) begin n = n + 6'd1; end
    return n;
  endfunction

  assign advance = s1_valid_q && q_ready_i;
  assign full    = s1_valid_q && !q_ready_i;
  assign accept  = push && !full;

  always_comb begin
    for (int i = 0; i < WordBits; i++) begin
      x_rev[i] = s1_x_q[WordBits-1-i];
    end
  end

  assign lz       = count_tz(x_rev);
  assign tz       = count_tz(s1_x_q);
  assign lz_clamp = (lz > 6'(LeadMax)) ? LeadMax : lz[LeadBits-1:0];
  assign reuse    = win_valid_q && (lz >= 6'(win_lead_q)) && (tz >= win_trail_q);

  always_comb begin
    entry      = '0;
    entry.data = s1_x_q;
    if (s1_raw_q) begin
      entry.kind = KIND_RAW;
      entry.len  = LenWord;
    end else if (s1_x_q == '0) begin
      entry.kind = KIND_ZERO;
      entry.len  = LenZero;
    end else if (reuse) begin
      entry.kind  = KIND_REUSE;
      entry.shamt = win_trail_q;
      entry.lead  = win_lead_q;
      entry.len   = LenWord - {2'b00, win_lead_q} - {1'b0, win_trail_q};
    end else begin
      entry.kind  = KIND_NEW;
      entry.shamt = tz;
      entry.lead  = lz_clamp;
      entry.len   = LenWord - {2'b00, lz_clamp} - {1'b0, tz};
    end
  end

  assign q_push_o  = advance;
  assign q_entry_o = entry;

  always_comb begin
    prev_seen_d = prev_seen_q;
    prev_d      = prev_q;
    s1_raw_d    = s1_raw_q;
    s1_x_d      = s1_x_q;
    s1_valid_d  = s1_valid_q;
    if (advance) begin
      s1_valid_d = 1'b0;
    end
    if (accept) begin
      s1_valid_d  = 1'b1;
      s1_raw_d    = !prev_seen_q;
      s1_x_d      = prev_seen_q ? (value_i ^ prev_q) : value_i;
      prev_d      = value_i;
      prev_seen_d = 1'b1;
    end
    win_valid_d = win_valid_q;
    win_lead_d  = win_lead_q;
    win_trail_d = win_trail_q;
    if (advance && entry.kind == KIND_NEW) begin
      win_valid_d = 1'b1;
      win_lead_d  = lz_clamp;
      win_trail_d = tz;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_seen_q <= 1'b0;
      prev_q      <= '0;
      s1_valid_q  <= 1'b0;
      s1_raw_q    <= 1'b0;
      win_valid_q <= 1'b0;
      win_lead_q  <= '0;
      win_trail_q <= '0;
    end else begin
      prev_seen_q <= prev_seen_d;
      prev_q      <= prev_d;
      s1_valid_q  <= s1_valid_d;
      s1_raw_q    <= s1_raw_d;
      win_valid_q <= win_valid_d;
      win_lead_q  <= win_lead_d;
      win_trail_q <= win_trail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_x_q <= s1_x_d;
  end

endmodule

/* design/xdse_queue.sv */
// Short FIFO of classified entries between front and back.
// Uses xdse_pkg.
module xdse_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  xdse_pkg::xdse_entry_t   entry_i,
  output logic                    ready_o,
  output logic                    valid_o,
  output xdse_pkg::xdse_entry_t   entry_o,
  input  logic                    pop_i
);
  import xdse_pkg::*;

  localparam int unsigned PtrBits = $clog2(QDepth);
  localparam int unsigned CntBits = $clog2(QDepth + 1);

  xdse_entry_t        mem_q [QDepth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  function automatic logic [PtrBits-1:0] ptr_inc(input logic [PtrBits-1:0] p);
    return (p == PtrBits'(QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign ready_o = (cnt_q != CntBits'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

/* design/xdse_back.sv */
// Back end: turns each queued entry into one or two chunks and holds
// the current chunk in an output register. Uses xdse_pkg and the defines header.
`include "xor_double_stream_encoder_unit_defines.svh"

module xdse_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  input  xdse_pkg::xdse_entry_t   q_entry_i,
  output logic                    q_pop_o,
  output logic                    empty,
  input  logic                    pop,
  output logic [63:0]             chunk_bits_o,
  output logic [6:0]              chunk_length_o,
  output logic                    last_o
);
  import xdse_pkg::*;

  logic                out_valid_q, out_valid_d;
  logic                phase_q, phase_d;
  logic [WordBits-1:0] bits_q, bits_d;
  logic [6:0]          len_q, len_d;
  logic                last_q, last_d;
  logic                load;
  logic [WordBits-1:0] payload;

  assign load    = q_valid_i && (!out_valid_q || pop);
  assign payload = q_entry_i.data >> q_entry_i.shamt;

  always_comb begin
    bits_d = '0;
    len_d  = LenZero;
    last_d = 1'b1;
    case (q_entry_i.kind)
      KIND_RAW: begin
        bits_d = q_entry_i.data;
        len_d  = LenWord;
      end
      KIND_ZERO: begin
        bits_d = '0;
        len_d  = LenZero;
      end
      KIND_REUSE: begin
        if (phase_q) begin
          bits_d = payload;
          len_d  = q_entry_i.len;
        end else begin
          bits_d = WordBits'(CtlReuse);
          len_d  = LenCtl;
          last_d = 1'b0;
        end
      end
      KIND_NEW: begin
        if (phase_q) begin
          bits_d = payload;
          len_d  = q_entry_i.len;
        end else begin
          // '11', 5-bit lead, 6-bit length (64 wraps to 0)
          bits_d = WordBits'({CtlNew, q_entry_i.lead, q_entry_i.len[LenBits-1:0]});
          len_d  = LenHdr;
          last_d = 1'b0;
        end
      end
      default: begin
        bits_d = '0;
      end
    endcase
  end

  assign q_pop_o = load && last_d;

  always_comb begin
    phase_d     = load ? !last_d : phase_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bits_q <= bits_d;
      len_q  <= len_d;
      last_q <= last_d;
    end
  end

  assign empty          = !out_valid_q;
  assign chunk_bits_o   = bits_q;
  assign chunk_length_o = len_q;
  assign last_o         = last_q;

  `XDSE_ASSERT_NOW(a_phase_has_entry, phase_q, q_valid_i, "second chunk pending without entry")
  `XDSE_ASSERT_NOW(a_len_range, out_valid_q, (len_q != '0) && (len_q <= LenWord), "bad chunk length")
  `XDSE_ASSERT_NEXT(a_hdr_then_payload, load && !last_d, phase_q, "header not followed by payload")
  `XDSE_ASSERT_NOW(a_pop_only_on_last, q_pop_o, load && last_d, "entry dropped early")

endmodule
